[rtl/bkd_pkg.sv]
// Shared types and constants for the bounded knapsack DP unit.
// No dependencies; imported by every module of the block except bkd_ram.
`default_nettype none

package bkd_pkg;

    localparam int MAX_CAPACITY_DEF = 1024;

    localparam int CAP_W   = 10;  // capacity register
    localparam int WT_W    = 10;  // item weight
    localparam int VAL_W   = 16;  // item value
    localparam int CNT_W   = 16;  // item copy limit
    localparam int GAIN_W  = 32;  // count * value, k * value
    localparam int BEST_W  = 63;  // table entry / answer

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_TRIAL,
        ST_WRITE,
        ST_ANS_RD,
        ST_ANS,
        ST_CLEAR
    } seq_state_t;

    typedef struct packed {
        logic in_ready;
        logic ans_load;
    } seq_ctl_t;

endpackage

`default_nettype wire

[rtl/bkd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module bkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bkd_satmax.sv]
// Shared arithmetic unit: saturating 63-bit add followed by a running maximum.
// Depends on bkd_pkg for widths.
`default_nettype none

module bkd_satmax
    import bkd_pkg::*;
(
    input  wire logic [BEST_W-1:0] cur,
    input  wire logic [BEST_W-1:0] a,
    input  wire logic [GAIN_W-1:0] b,
    output logic      [BEST_W-1:0] y
);

    logic [BEST_W:0]   sum;
    logic [BEST_W-1:0] sat;

    always_comb begin
        sum = {1'b0, a} + {{(BEST_W + 1 - GAIN_W){1'b0}}, b};
        sat = sum[BEST_W] ? {BEST_W{1'b1}} : sum[BEST_W-1:0];
        y   = (sat > cur) ? sat : cur;
    end

endmodule

`default_nettype wire

[rtl/bkd_seq.sv]
// Sequencer: sweeps the table per item, drives the RAM and the shared unit,
// reads the answer and clears the table. Depends on bkd_pkg and bkd_satmax.
`default_nettype none

module bkd_seq
    import bkd_pkg::*;
#(
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
    parameter int AW           = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [AW-1:0]     cap_use,
    input  wire logic              in_valid,
    input  wire logic [WT_W-1:0]   in_weight,
    input  wire logic [VAL_W-1:0]  in_value,
    input  wire logic [CNT_W-1:0]  in_count,
    input  wire logic              in_last,
    input  wire logic              out_busy,
    input  wire logic [BEST_W-1:0] rd_data,
    output seq_ctl_t               ctl,
    output logic                   ram_we,
    output logic      [AW-1:0]     ram_waddr,
    output logic      [BEST_W-1:0] ram_wdata,
    output logic                   ram_re,
    output logic      [AW-1:0]     ram_raddr
);

    localparam int CMPW = (AW > WT_W) ? AW : WT_W;

    seq_state_t state_reg, state_next;

    logic [WT_W-1:0]   wt_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [GAIN_W-1:0] kval_reg, kval_next;
    logic [BEST_W-1:0] best_reg, best_next;
    logic [AW-1:0]     clr_reg, clr_next;

    logic              accept;
    logic              zero_wt;
    logic [CMPW-1:0]   wt_ext;
    logic [CMPW-1:0]   j_ext;
    logic [CMPW-1:0]   addr_ext;
    logic              j_fits;
    logic              addr_fits;
    logic              trial_more;

    logic [BEST_W-1:0] u_cur;
    logic [GAIN_W-1:0] u_b;
    logic [BEST_W-1:0] u_y;

    bkd_satmax u_satmax (
        .cur (u_cur),
        .a   (rd_data),
        .b   (u_b),
        .y   (u_y)
    );

    always_comb begin
        accept     = in_valid && (state_reg == ST_IDLE);
        zero_wt    = (wt_reg == '0);
        wt_ext     = CMPW'(wt_reg);
        j_ext      = CMPW'(j_reg);
        addr_ext   = CMPW'(addr_reg);
        j_fits     = (j_ext >= wt_ext);
        addr_fits  = (addr_ext >= wt_ext);
        trial_more = (k_reg != cnt_reg) && addr_fits;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_count == '0) begin
                        state_next = in_last ? ST_ANS_RD : ST_IDLE;
                    end else begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                state_next = (!zero_wt && j_fits) ? ST_TRIAL : ST_WRITE;
            end
            ST_TRIAL: begin
                state_next = trial_more ? ST_TRIAL : ST_WRITE;
            end
            ST_WRITE: begin
                if (j_reg == '0) begin
                    state_next = last_reg ? ST_ANS_RD : ST_IDLE;
                end else begin
                    state_next = ST_BASE;
                end
            end
            ST_ANS_RD: begin
                state_next = ST_ANS;
            end
            ST_ANS: begin
                state_next = out_busy ? ST_ANS : ST_CLEAR;
            end
            ST_CLEAR: begin
                state_next = (clr_reg == AW'(MAX_CAPACITY - 1)) ? ST_IDLE : ST_CLEAR;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        j_next       = j_reg;
        addr_next    = addr_reg;
        k_next       = k_reg;
        kval_next    = kval_reg;
        best_next    = best_reg;
        clr_next     = clr_reg;
        u_cur        = '0;
        u_b          = '0;
        ram_we       = 1'b0;
        ram_waddr    = j_reg;
        ram_wdata    = best_reg;
        ram_re       = 1'b0;
        ram_raddr    = j_reg;
        ctl.in_ready = 1'b0;
        ctl.ans_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ctl.in_ready = 1'b1;
                j_next       = cap_use;
                ram_raddr    = cap_use;
                ram_re       = accept && (in_count != '0);
            end
            ST_BASE: begin
                u_cur     = '0;
                u_b       = zero_wt ? gain_reg : '0;
                best_next = u_y;
                if (!zero_wt && j_fits) begin
                    addr_next = AW'(j_ext - wt_ext);
                    k_next    = CNT_W'(1);
                    kval_next = GAIN_W'(val_reg);
                    ram_re    = 1'b1;
                    ram_raddr = AW'(j_ext - wt_ext);
                end
            end
            ST_TRIAL: begin
                u_cur     = best_reg;
                u_b       = kval_reg;
                best_next = u_y;
                if (trial_more) begin
                    addr_next = AW'(addr_ext - wt_ext);
                    k_next    = k_reg + CNT_W'(1);
                    kval_next = kval_reg + GAIN_W'(val_reg);
                    ram_re    = 1'b1;
                    ram_raddr = AW'(addr_ext - wt_ext);
                end
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = best_reg;
                if (j_reg != '0) begin
                    j_next    = j_reg - AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = j_reg - AW'(1);
                end
            end
            ST_ANS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cap_use;
            end
            ST_ANS: begin
                clr_next = '0;
                if (!out_busy) begin
                    ctl.ans_load = 1'b1;
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            default: begin
                ctl.in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            wt_reg   <= in_weight;
            val_reg  <= in_value;
            cnt_reg  <= in_count;
            last_reg <= in_last;
            gain_reg <= GAIN_W'(in_count) * GAIN_W'(in_value);
        end
        j_reg    <= j_next;
        addr_reg <= addr_next;
        k_reg    <= k_next;
        kval_reg <= kval_next;
        best_reg <= best_next;
    end

endmodule

`default_nettype wire

[rtl/bounded_knapsack_dp_unit.sv]
// Bounded knapsack DP unit: top level with stream ports, capacity register,
// result register, sequencer and table RAM. Depends on bkd_pkg, bkd_seq, bkd_ram.
//
// Each input transfer folds one item type into a table of best values held in a
// single-port-read, single-port-write RAM; one saturating add/max unit computes
// every new table value. An item with a zero copy limit leaves the table as it
// is. Otherwise the item sweeps capacities j = cap..0 and, at each j, makes
// L(j) = min(count, j / weight) trials, one RAM read each (L = 0 for a zero
// weight). An item marked tlast then has the answer read and the table cleared,
// all MAX_CAPACITY entries; the same clearing pass runs after reset. s_tready is
// low during all of this. The answer waits in an output register; the block
// moves on to the clearing pass once that register is free. Capacity may be
// written only while idle.
`default_nettype none

module bounded_knapsack_dp_unit
    import bkd_pkg::*;
#(
    parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CAP_W-1:0]     cfg_data,     // capacity
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,      // item_weight, item_value, item_count
    input  wire logic                 s_tlast,      // last_item
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata       // best_value
);

    localparam int AW   = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CMPW = (AW > CAP_W) ? AW : CAP_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [AW-1:0]     cap_use;
    logic [CMPW-1:0]   cap_ext;
    logic [CMPW-1:0]   cap_lim;

    logic              out_valid_reg;
    logic [BEST_W-1:0] out_data_reg;
    logic              out_busy;

    seq_ctl_t          ctl;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BEST_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BEST_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        cap_ext = CMPW'(capacity_reg);
        cap_lim = CMPW'(MAX_CAPACITY - 1);
        cap_use = (cap_ext > cap_lim) ? AW'(cap_lim) : AW'(cap_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    bkd_seq #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .AW           (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_use   (cap_use),
        .in_valid  (s_tvalid),
        .in_weight (s_tdata[WT_W-1:0]),
        .in_value  (s_tdata[WT_W+VAL_W-1:WT_W]),
        .in_count  (s_tdata[WT_W+VAL_W+CNT_W-1:WT_W+VAL_W]),
        .in_last   (s_tlast),
        .out_busy  (out_busy),
        .rd_data   (ram_rdata),
        .ctl       (ctl),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    bkd_ram #(
        .WIDTH (BEST_W),
        .DEPTH (MAX_CAPACITY),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = ctl.in_ready;
    assign out_busy = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.ans_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ans_load) begin
            out_data_reg <= ram_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BEST_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire
